// ----- hw/rtl/lagged_subtractive_random_generator_assert.svh -----
// Assertion macros shared by the checker.
`ifndef LAGGED_SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH
`define LAGGED_SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH

// Clocked implication, off during reset.
`define LSRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked implication that also holds while reset is high.
`define LSRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lsrg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lsrg_pkg;
  localparam int LONG_LAG    = 100;
  localparam int SHORT_LAG   = 37;
  localparam int LAG_GAP     = LONG_LAG - SHORT_LAG;
  localparam int SCR_LEN     = 2 * LONG_LAG - 1;
  localparam int WORD_W      = 30;
  localparam int RING_AW     = $clog2(LONG_LAG);
  localparam int SCR_AW      = $clog2(SCR_LEN);
  localparam int ROUNDS_INIT = 69;
  localparam int WARM_DRAWS  = 10 * SCR_LEN;
  localparam int WARM_W      = $clog2(WARM_DRAWS);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_SEED, OP_BOOT, OP_SPREAD_RD, OP_SPREAD_WR, OP_SUB_RD, OP_SUB_W1,
    OP_SUB_W2, OP_SHIFT_RD, OP_SHIFT_WR, OP_ROT_RD, OP_ROT_W0, OP_ROT_W37,
    OP_BITS, OP_LOAD_RD, OP_LOAD_WR, OP_DRAW_RD, OP_DRAW_WR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SCR_AW-1:0] idx;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic bit0;
    logic bits_zero;
    logic out_full;
  } sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/lsrg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsrg_ram #(
  parameter int W     = 30,
  parameter int DEPTH = 100,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [W-1:0]  wd,
  input  wire logic [AW-1:0] ra0,
  input  wire logic [AW-1:0] ra1,
  output logic      [W-1:0]  rd0,
  output logic      [W-1:0]  rd1
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lsrg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsrg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_reseed,
  output logic               in_ready,
  input  wire lsrg_pkg::sts_t sts,
  output lsrg_pkg::cmd_t     cmd
);
  import lsrg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_BOOT, S_SPREAD_RD, S_SPREAD_WR, S_SUB_RD, S_SUB_W1,
    S_SUB_W2, S_SHIFT_RD, S_SHIFT_WR, S_ROT_RD, S_ROT_W0, S_ROT_W37,
    S_BITS, S_LOAD_RD, S_LOAD_WR, S_DRAW_RD, S_DRAW_WR
  } state_t;

  state_t            state;
  logic [SCR_AW-1:0] idx;
  logic [6:0]        rounds;
  logic [WARM_W-1:0] warm;
  logic              warm_mode;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.idx      = idx;
    cmd.out_load = !warm_mode;
    unique case (state)
      // seed is taken on the accepting edge itself
      S_IDLE:      cmd.op = (in_valid && in_reseed) ? OP_SEED : OP_NOP;
      S_BOOT:      cmd.op = OP_BOOT;
      S_SPREAD_RD: cmd.op = OP_SPREAD_RD;
      S_SPREAD_WR: cmd.op = OP_SPREAD_WR;
      S_SUB_RD:    cmd.op = OP_SUB_RD;
      S_SUB_W1:    cmd.op = OP_SUB_W1;
      S_SUB_W2:    cmd.op = OP_SUB_W2;
      S_SHIFT_RD:  cmd.op = OP_SHIFT_RD;
      S_SHIFT_WR:  cmd.op = OP_SHIFT_WR;
      S_ROT_RD:    cmd.op = OP_ROT_RD;
      S_ROT_W0:    cmd.op = OP_ROT_W0;
      S_ROT_W37:   cmd.op = OP_ROT_W37;
      S_BITS:      cmd.op = OP_BITS;
      S_LOAD_RD:   cmd.op = OP_LOAD_RD;
      S_LOAD_WR:   cmd.op = OP_LOAD_WR;
      S_DRAW_RD:   cmd.op = OP_DRAW_RD;
      S_DRAW_WR:   cmd.op = (!warm_mode && sts.out_full) ? OP_NOP : OP_DRAW_WR;
      default:     cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      rounds    <= '0;
      warm      <= '0;
      warm_mode <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            warm_mode <= 1'b0;
            if (in_reseed) begin
              idx    <= '0;
              rounds <= 7'(ROUNDS_INIT);
              state  <= S_BOOT;
            end else begin
              state <= S_DRAW_RD;
            end
          end
        end
        S_BOOT: begin
          if (idx == SCR_AW'(LONG_LAG - 1)) begin
            state <= S_SPREAD_RD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SPREAD_RD: state <= S_SPREAD_WR;
        S_SPREAD_WR: begin
          if (idx == SCR_AW'(1)) begin
            idx   <= SCR_AW'(SCR_LEN - 1);
            state <= S_SUB_RD;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_SPREAD_RD;
          end
        end
        S_SUB_RD: state <= S_SUB_W1;
        S_SUB_W1: state <= S_SUB_W2;
        S_SUB_W2: begin
          if (idx == SCR_AW'(LONG_LAG)) begin
            state <= sts.bit0 ? S_SHIFT_RD : S_BITS;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_SUB_RD;
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (idx == SCR_AW'(1)) begin
            state <= S_ROT_RD;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_SHIFT_RD;
          end
        end
        S_ROT_RD:  state <= S_ROT_W0;
        S_ROT_W0:  state <= S_ROT_W37;
        S_ROT_W37: state <= S_BITS;
        S_BITS: begin
          if (sts.bits_zero && rounds == 7'd1) begin
            idx   <= '0;
            state <= S_LOAD_RD;
          end else begin
            if (sts.bits_zero) begin
              rounds <= rounds - 1'b1;
            end
            idx   <= SCR_AW'(LONG_LAG - 1);
            state <= S_SPREAD_RD;
          end
        end
        S_LOAD_RD: state <= S_LOAD_WR;
        S_LOAD_WR: begin
          if (idx == SCR_AW'(LONG_LAG - 1)) begin
            warm      <= '0;
            warm_mode <= 1'b1;
            state     <= S_DRAW_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_LOAD_RD;
          end
        end
        S_DRAW_RD: state <= S_DRAW_WR;
        S_DRAW_WR: begin
          if (warm_mode) begin
            if (warm == WARM_W'(WARM_DRAWS - 1)) begin
              state <= S_IDLE;
            end else begin
              warm  <= warm + 1'b1;
              state <= S_DRAW_RD;
            end
          end else if (!sts.out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lsrg_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsrg_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lsrg_pkg::cmd_t cmd,
  output lsrg_pkg::sts_t      sts,
  input  wire lsrg_pkg::word_t seed,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lsrg_pkg::word_t     out_data
);
  import lsrg_pkg::*;

  logic              s_we;
  logic [SCR_AW-1:0] s_wa, s_ra0, s_ra1;
  word_t             s_wd, s_rd0, s_rd1;
  logic               r_we;
  logic [RING_AW-1:0] r_wa, head, hp;
  word_t              r_wd, r_rd0, r_rd1, ring_a, ring_b;
  logic [LONG_LAG-1:0] valid;
  logic               rv0, rv1;
  word_t              ss, bits, xa, xb;
  logic [SCR_AW-1:0]  idx2, hsum;

  assign idx2 = {cmd.idx[SCR_AW-2:0], 1'b0};
  assign hsum = SCR_AW'(head) + SCR_AW'(LAG_GAP);
  assign hp   = (hsum >= SCR_AW'(LONG_LAG)) ? RING_AW'(hsum - SCR_AW'(LONG_LAG))
                                            : RING_AW'(hsum);
  assign ring_a = rv0 ? r_rd0 : '0;
  assign ring_b = rv1 ? r_rd1 : '0;

  assign sts.bit0      = bits[0];
  assign sts.bits_zero = (bits == '0);
  assign sts.out_full  = out_valid && !out_ready;

  always_comb begin
    s_we  = 1'b0;
    s_wa  = '0;
    s_wd  = '0;
    s_ra0 = '0;
    s_ra1 = '0;
    r_we  = 1'b0;
    r_wa  = head;
    r_wd  = '0;
    unique case (cmd.op)
      OP_BOOT: begin
        s_we = 1'b1;
        s_wa = cmd.idx;
        s_wd = (cmd.idx == SCR_AW'(1)) ? ss + 1'b1 : ss;
      end
      OP_SPREAD_RD: begin
        s_ra0 = cmd.idx;
        s_we  = 1'b1;
        s_wa  = idx2 - 1'b1;
      end
      OP_SPREAD_WR: begin
        s_we = 1'b1;
        s_wa = idx2;
        s_wd = s_rd0;
      end
      OP_SUB_RD: begin
        s_ra0 = cmd.idx;
        s_ra1 = cmd.idx - SCR_AW'(LAG_GAP);
      end
      OP_SUB_W1: begin
        s_we  = 1'b1;
        s_wa  = cmd.idx - SCR_AW'(LAG_GAP);
        s_wd  = s_rd1 - s_rd0;
        s_ra0 = cmd.idx - SCR_AW'(LONG_LAG);
      end
      OP_SUB_W2: begin
        s_we = 1'b1;
        s_wa = cmd.idx - SCR_AW'(LONG_LAG);
        s_wd = s_rd0 - xa;
      end
      OP_SHIFT_RD: s_ra0 = cmd.idx - 1'b1;
      OP_SHIFT_WR: begin
        s_we = 1'b1;
        s_wa = cmd.idx;
        s_wd = s_rd0;
      end
      OP_ROT_RD: begin
        s_ra0 = SCR_AW'(LONG_LAG);
        s_ra1 = SCR_AW'(SHORT_LAG);
      end
      OP_ROT_W0: begin
        s_we = 1'b1;
        s_wd = s_rd0;
      end
      OP_ROT_W37: begin
        s_we = 1'b1;
        s_wa = SCR_AW'(SHORT_LAG);
        s_wd = xb - xa;
      end
      OP_LOAD_RD: s_ra0 = cmd.idx;
      OP_LOAD_WR: begin
        r_we = 1'b1;
        r_wa = (cmd.idx < SCR_AW'(SHORT_LAG)) ? RING_AW'(cmd.idx + SCR_AW'(LAG_GAP))
                                            : RING_AW'(cmd.idx - SCR_AW'(SHORT_LAG));
        r_wd = s_rd0;
      end
      OP_DRAW_WR: begin
        r_we = 1'b1;
        r_wd = ring_a - ring_b;
      end
      default: ;
    endcase
  end

  lsrg_ram #(.W(WORD_W), .DEPTH(SCR_LEN)) u_scratch (
    .clk(clk), .we(s_we), .wa(s_wa), .wd(s_wd),
    .ra0(s_ra0), .ra1(s_ra1), .rd0(s_rd0), .rd1(s_rd1)
  );

  lsrg_ram #(.W(WORD_W), .DEPTH(LONG_LAG)) u_ring (
    .clk(clk), .we(r_we), .wa(r_wa), .wd(r_wd),
    .ra0(head), .ra1(hp), .rd0(r_rd0), .rd1(r_rd1)
  );

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    rv0 <= valid[head];
    rv1 <= valid[hp];
    unique case (cmd.op)
      OP_SEED: begin
        ss   <= (seed + WORD_W'(2)) & ~WORD_W'(1);
        bits <= seed;
      end
      OP_BOOT:   ss <= {ss[WORD_W-2:0], 1'b0} + (ss[WORD_W-1] ? WORD_W'(2) : '0);
      OP_BITS:   if (bits != '0) bits <= bits >> 1;
      OP_SUB_W1: xa <= s_rd0;
      OP_ROT_W0: begin
        xa <= s_rd0;
        xb <= s_rd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (r_we) begin
        valid[r_wa] <= 1'b1;
      end
      if (cmd.op == OP_LOAD_RD && cmd.idx == '0) begin
        head <= '0;
      end else if (cmd.op == OP_DRAW_WR) begin
        head <= (head == RING_AW'(LONG_LAG - 1)) ? '0 : head + 1'b1;
      end
      if (cmd.op == OP_DRAW_WR && cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DRAW_WR && cmd.out_load) begin
      out_data <= ring_a;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lagged_subtractive_random_generator.sv -----
// Draw: after the transfer, a ring read and then a write-back into the output register, which
// waits while that register is full; the next request is accepted only after the write-back.
// Reseed: sequencer over the 199-word scratch RAM, its length depending on the seed bits,
// then warm-up draws into the ring; no result.
// Reset (rst, synchronous): sequencer idle, ring reads as all zeros, head at zero.
`timescale 1ns / 1ps
`default_nettype none
module lagged_subtractive_random_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [29:0] seed, [31:30] zero
  input  wire logic        s_tuser,  // [0] req_type: 0 draw, 1 reseed
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // [29:0] value, [31:30] zero
);
  import lsrg_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  word_t value;
  word_t seed;

  assign seed    = s_tdata[WORD_W-1:0];
  assign m_tdata = {2'b00, value};

  // Sequencer: accepts a transfer only when idle; a draw may be taken while
  // the previous result still sits in the output register.
  lsrg_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_reseed(s_tuser), .in_ready(s_tready),
    .sts(sts), .cmd(cmd)
  );

  // Ring and scratch RAMs, seeding arithmetic, output register.
  lsrg_dp u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .sts(sts), .seed(seed),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(value)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/lsrg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "lagged_subtractive_random_generator_assert.svh"
module lsrg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);
  `LSRG_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
  `LSRG_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
  `LSRG_ASSERT(a_busy, s_tvalid && s_tready |=> !s_tready, "accepted while busy")
  `LSRG_ASSERT_ALWAYS(a_reseed_quiet, !rst && s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid, "reseed made a result")
endmodule

bind lagged_subtractive_random_generator lsrg_checker u_lsrg_checker (.*);
`default_nettype wire
